@@ sv/assert_macros.svh @@
// Assertion helpers for the top-level file, which checks behaviour with them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked at every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/sds_pkg.sv @@
// ----------------------------------------------------------------------------
// sds_pkg: shared types and codes of the skeleton distance shader
// Item kinds, result status codes, result selectors and the control bundle
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package sds_pkg;

  localparam int unsigned SUM_BITS = 27;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  localparam logic [1:0] KIND_SKEL   = 2'd0;
  localparam logic [1:0] KIND_VERT   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SKEL   = 3'd1;
  localparam logic [2:0] ST_NO_VERT   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  localparam logic [2:0] RES_SKEL_OK = 3'd0;
  localparam logic [2:0] RES_FULL    = 3'd1;
  localparam logic [2:0] RES_NO_SKEL = 3'd2;
  localparam logic [2:0] RES_NO_VERT = 3'd3;
  localparam logic [2:0] RES_BAD_IDX = 3'd4;
  localparam logic [2:0] RES_LOAD    = 3'd5;
  localparam logic [2:0] RES_QUERY   = 3'd6;

  typedef struct packed {
    logic       capture;
    logic       scan_start;
    logic       sqrt_start;
    logic       q_read;
    logic       q_mul;
    logic       q_scale;
    logic       div_start;
    logic       out_load;
    logic [2:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       skel_empty;
    logic       skel_full;
    logic       vert_empty;
    logic       vert_full;
    logic       q_bad;
    logic       scan_done;
    logic       sqrt_done;
    logic       div_done;
  } stat_t;

endpackage
`default_nettype wire

@@ sv/sds_ram.sv @@
// ----------------------------------------------------------------------------
// sds_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ sv/sds_ctrl.sv @@
// ----------------------------------------------------------------------------
// sds_ctrl: sequencer of the skeleton distance shader
// Decodes each item, starts the scan, root and divide steps in the datapath
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sds_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire sds_pkg::stat_t stat,
  output sds_pkg::cmd_t      cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SQRT   = 4'd3;
  localparam logic [3:0] S_QMUL   = 4'd4;
  localparam logic [3:0] S_QSCALE = 4'd5;
  localparam logic [3:0] S_QSTART = 4'd6;
  localparam logic [3:0] S_QDIV   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state, state_next;
  logic [2:0] res, res_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    cmd.res_sel = res;
    unique case (state)
      S_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          sds_pkg::KIND_SKEL: begin
            res_next   = stat.skel_full ? sds_pkg::RES_FULL : sds_pkg::RES_SKEL_OK;
            state_next = S_FINISH;
          end
          sds_pkg::KIND_VERT: begin
            if (stat.skel_empty) begin
              res_next   = sds_pkg::RES_NO_SKEL;
              state_next = S_FINISH;
            end else if (stat.vert_full) begin
              res_next   = sds_pkg::RES_FULL;
              state_next = S_FINISH;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          sds_pkg::KIND_QUERY: begin
            if (stat.vert_empty) begin
              res_next   = sds_pkg::RES_NO_VERT;
              state_next = S_FINISH;
            end else if (stat.q_bad) begin
              res_next   = sds_pkg::RES_BAD_IDX;
              state_next = S_FINISH;
            end else begin
              cmd.q_read = 1'b1;
              state_next = S_QMUL;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          res_next   = sds_pkg::RES_LOAD;
          state_next = S_FINISH;
        end
      end
      S_QMUL: begin
        cmd.q_mul  = 1'b1;
        state_next = S_QSCALE;
      end
      S_QSCALE: begin
        cmd.q_scale = 1'b1;
        state_next  = S_QSTART;
      end
      S_QSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_QDIV;
      end
      S_QDIV: begin
        if (stat.div_done) begin
          res_next   = sds_pkg::RES_QUERY;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res      <= sds_pkg::RES_SKEL_OK;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      res   <= res_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/sds_datapath.sv @@
// ----------------------------------------------------------------------------
// sds_datapath: stores, nearest-point scan, root and shade divide
// Holds the skeleton and vertex stores, the counts and the running sum, and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sds_datapath #(
  parameter int SKELETON_DEPTH = 1024,
  parameter int MESH_DEPTH     = 1024,
  parameter int COORD_BITS     = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sds_pkg::cmd_t cmd,
  output sds_pkg::stat_t     stat,
  input  wire logic [1:0]    in_kind,
  input  wire logic [15:0]   in_x,
  input  wire logic [15:0]   in_y,
  input  wire logic [15:0]   in_z,
  input  wire logic [9:0]    in_q,
  output logic      [2:0]    status,
  output logic      [16:0]   distance,
  output logic      [9:0]    vertex_index,
  output logic      [7:0]    shade
);
  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int SQW  = 2 * C + 2;
  localparam int SAW  = SKELETON_DEPTH > 1 ? $clog2(SKELETON_DEPTH) : 1;
  localparam int SCW  = $clog2(SKELETON_DEPTH + 1);
  localparam int VAW  = MESH_DEPTH > 1 ? $clog2(MESH_DEPTH) : 1;
  localparam int VCW  = $clog2(MESH_DEPTH + 1);
  localparam int PW   = DW + VCW;
  localparam int NW   = PW + 8;
  localparam int SB   = sds_pkg::SUM_BITS;
  localparam int CMPW = (NW > SB + 8 ? NW : SB + 8) + 1;
  localparam int RCW  = $clog2(DW + 1);

  // Captured item.
  logic [1:0]   kind;
  logic [C-1:0] px, py, pz;
  logic [9:0]   q;

  logic [SCW-1:0] skel_count;
  logic [VCW-1:0] vert_count;
  logic [SB-1:0]  sum;

  // Scan pipeline.
  logic           scan_run, v1, v2, scan_done;
  logic [SCW-1:0] scan_idx;
  logic [3*C-1:0] skel_rdata;
  logic [2*C-1:0] sqx, sqy, sqz;
  logic [SQW-1:0] best, sq_sum;

  // Integer root.
  logic [SQW-1:0] rad;
  logic [DW+1:0]  rrem;
  logic [DW-1:0]  root;
  logic [RCW-1:0] rcnt;
  logic           sqrt_done;
  logic [DW+3:0]  rs, rtrial;

  // Query and divide.
  logic [DW-1:0]   vert_rdata, dq;
  logic [PW-1:0]   prod;
  logic [NW-1:0]   num;
  logic [CMPW-1:0] drem, dsh;
  logic [7:0]      quo;
  logic [3:0]      dcnt;
  logic            ovf, div_done;

  logic           skel_we, vert_we;
  logic [SB:0]    sum_wide;

  // Result fields for the output register.
  logic [2:0]  status_next;
  logic [16:0] distance_next;
  logic [9:0]  vertex_index_next;
  logic [7:0]  shade_next;

  function automatic logic [C:0] absdiff(input logic [C-1:0] a, input logic [C-1:0] b);
    logic signed [C:0] d;
    d = $signed({a[C-1], a}) - $signed({b[C-1], b});
    absdiff = d[C] ? -d : d;
  endfunction

  logic [C:0] ax, ay, az;
  assign ax = absdiff(px, skel_rdata[C-1:0]);
  assign ay = absdiff(py, skel_rdata[2*C-1:C]);
  assign az = absdiff(pz, skel_rdata[3*C-1:2*C]);
  assign sq_sum = SQW'(sqx) + SQW'(sqy) + SQW'(sqz);

  assign skel_we = cmd.out_load && (cmd.res_sel == sds_pkg::RES_SKEL_OK);
  assign vert_we = cmd.out_load && (cmd.res_sel == sds_pkg::RES_LOAD);
  assign sum_wide = (SB + 1)'(sum) + (SB + 1)'(root);

  sds_ram #(.WIDTH(3 * C), .DEPTH(SKELETON_DEPTH)) u_skel_ram (
    .clk   (clk),
    .we    (skel_we),
    .waddr (skel_count[SAW-1:0]),
    .wdata ({pz, py, px}),
    .re    (scan_run),
    .raddr (scan_idx[SAW-1:0]),
    .rdata (skel_rdata)
  );

  sds_ram #(.WIDTH(DW), .DEPTH(MESH_DEPTH)) u_vert_ram (
    .clk   (clk),
    .we    (vert_we),
    .waddr (vert_count[VAW-1:0]),
    .wdata (root),
    .re    (cmd.q_read),
    .raddr (VAW'(q)),
    .rdata (vert_rdata)
  );

  always_comb begin
    stat            = '0;
    stat.kind       = kind;
    stat.skel_empty = (skel_count == '0);
    stat.skel_full  = (skel_count == SCW'(SKELETON_DEPTH));
    stat.vert_empty = (vert_count == '0);
    stat.vert_full  = (vert_count == VCW'(MESH_DEPTH));
    stat.q_bad      = ((VCW + 10)'(q) >= (VCW + 10)'(vert_count));
    stat.scan_done  = scan_done;
    stat.sqrt_done  = sqrt_done;
    stat.div_done   = div_done;
  end

  always_comb begin
    status_next       = sds_pkg::ST_OK;
    distance_next     = '0;
    vertex_index_next = '0;
    shade_next        = '0;
    unique case (cmd.res_sel)
      sds_pkg::RES_SKEL_OK: status_next = sds_pkg::ST_OK;
      sds_pkg::RES_FULL:    status_next = sds_pkg::ST_FULL;
      sds_pkg::RES_NO_SKEL: status_next = sds_pkg::ST_NO_SKEL;
      sds_pkg::RES_NO_VERT: begin
        status_next       = sds_pkg::ST_NO_VERT;
        vertex_index_next = q;
      end
      sds_pkg::RES_BAD_IDX: begin
        status_next       = sds_pkg::ST_BAD_INDEX;
        vertex_index_next = q;
      end
      sds_pkg::RES_LOAD: begin
        distance_next     = 17'(root);
        vertex_index_next = 10'(vert_count);
      end
      sds_pkg::RES_QUERY: begin
        distance_next     = 17'(dq);
        vertex_index_next = q;
        shade_next        = (sum == '0) ? 8'd0 : (ovf ? 8'hFF : quo);
      end
      default: status_next = sds_pkg::ST_OK;
    endcase
  end

  // One root bit per step, two radicand bits consumed each time.
  assign rs     = {rrem, rad[SQW-1:SQW-2]};
  assign rtrial = (DW + 4)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      skel_count <= '0;
      vert_count <= '0;
      sum        <= '0;
      scan_run   <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      scan_done  <= 1'b0;
      rcnt       <= '0;
      sqrt_done  <= 1'b0;
      dcnt       <= '0;
      div_done   <= 1'b0;
    end else begin
      scan_done <= v2 && !v1 && !scan_run;
      v1        <= scan_run;
      v2        <= v1;
      if (cmd.scan_start) begin
        scan_run <= 1'b1;
      end else if (scan_run && (scan_idx + 1'b1 == skel_count)) begin
        scan_run <= 1'b0;
      end
      sqrt_done <= (rcnt == RCW'(1));
      if (cmd.sqrt_start) begin
        rcnt <= RCW'(DW);
      end else if (rcnt != '0) begin
        rcnt <= rcnt - 1'b1;
      end
      div_done <= (dcnt == 4'd1);
      if (cmd.div_start) begin
        dcnt <= 4'd8;
      end else if (dcnt != '0) begin
        dcnt <= dcnt - 1'b1;
      end
      if (skel_we) begin
        skel_count <= skel_count + 1'b1;
      end
      if (vert_we) begin
        vert_count <= vert_count + 1'b1;
        sum <= sum_wide[SB] ? sds_pkg::SUM_MAX : sum_wide[SB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= in_kind;
      px   <= C'(in_x);
      py   <= C'(in_y);
      pz   <= C'(in_z);
      q    <= in_q;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
      best     <= '1;
    end else begin
      if (scan_run) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (v2 && (sq_sum < best)) begin
        best <= sq_sum;
      end
    end
    if (v1) begin
      sqx <= ax[C-1:0] * ax[C-1:0];
      sqy <= ay[C-1:0] * ay[C-1:0];
      sqz <= az[C-1:0] * az[C-1:0];
    end
    if (cmd.sqrt_start) begin
      rad  <= best;
      rrem <= '0;
      root <= '0;
    end else if (rcnt != '0) begin
      rad <= rad << 2;
      if (rs >= rtrial) begin
        rrem <= (DW + 2)'(rs - rtrial);
        root <= {root[DW-2:0], 1'b1};
      end else begin
        rrem <= (DW + 2)'(rs);
        root <= {root[DW-2:0], 1'b0};
      end
    end
    if (cmd.q_mul) begin
      dq   <= vert_rdata;
      prod <= vert_rdata * vert_count;
    end
    if (cmd.q_scale) begin
      num <= (NW'(prod) << 8) - NW'(prod);
    end
    // Quotient below 256 unless the numerator reaches 256 times the sum.
    if (cmd.div_start) begin
      drem <= CMPW'(num);
      dsh  <= CMPW'(sum) << 7;
      quo  <= '0;
      ovf  <= (CMPW'(num) >= (CMPW'(sum) << 8));
    end else if (dcnt != '0) begin
      dsh <= dsh >> 1;
      if (drem >= dsh) begin
        drem <= drem - dsh;
        quo  <= {quo[6:0], 1'b1};
      end else begin
        quo <= {quo[6:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      status       <= status_next;
      distance     <= distance_next;
      vertex_index <= vertex_index_next;
      shade        <= shade_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/skeleton_distance_shader_top.sv @@
// ----------------------------------------------------------------------------
// skeleton_distance_shader_top: nearest skeleton distance and vertex shading
// Loads skeleton points, gives each mesh vertex its distance to the nearest
// point and shades queried vertices against the mean distance.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser: kind; tdata: x, y, z, query_index
//  m_axis   | out       | tdata: status, distance, vertex_index, shade
//
// A skeleton load or an error result is decided in the decode state. A vertex load
// walks the skeleton store, one read a cycle, then takes the integer root; the
// store's single read port sets the length of the walk. A query reads the vertex
// store and scales the product, then runs the eight-step shade divide.
// Reset is synchronous and clears counts and the sum; the stores need none.
// One item is in work at a time; a new beat is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module skeleton_distance_shader_top #(
  parameter int SKELETON_DEPTH = 1024,
  parameter int MESH_DEPTH     = 1024,
  parameter int COORD_BITS     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // x_coord, y_coord, z_coord, query_index, zero pad
  input  wire logic [1:0]  s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata   // status, distance, vertex_index, shade, zero pad
);
  sds_pkg::cmd_t  cmd;
  sds_pkg::stat_t stat;
  logic [2:0]  status;
  logic [16:0] distance;
  logic [9:0]  vertex_index;
  logic [7:0]  shade;

  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sds_datapath #(
    .SKELETON_DEPTH (SKELETON_DEPTH),
    .MESH_DEPTH     (MESH_DEPTH),
    .COORD_BITS     (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (s_tuser),
    .in_x         (s_tdata[15:0]),
    .in_y         (s_tdata[31:16]),
    .in_z         (s_tdata[47:32]),
    .in_q         (s_tdata[57:48]),
    .status       (status),
    .distance     (distance),
    .vertex_index (vertex_index),
    .shade        (shade)
  );

  assign m_tdata = {2'b00, shade, vertex_index, distance, status};

`include "assert_macros.svh"

  `ASSERT_NEXT(a_load_shows, clk, rst, cmd.out_load, m_tvalid)
  `ASSERT_NEXT(a_one_in_work, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPL(a_one_start, clk, rst, 1'b1,
               $onehot0({cmd.scan_start, cmd.sqrt_start, cmd.div_start, cmd.out_load}))
  `ASSERT_IMPL(a_no_load_on_stall, clk, rst, m_tvalid && !m_tready, !cmd.out_load)

endmodule
`default_nettype wire
